FILE: design/cha_pkg.sv
// Shared types, codes and CRC helpers for the checked handle allocator.
// Used by every module of the block; depends on nothing else.
package cha_pkg;

	localparam int ENTRIES_DEF = 1024;

	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_LOOKUP  = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_CRC     = 3'd1;
	localparam logic [2:0] ST_VERSION = 3'd2;
	localparam logic [2:0] ST_ROOT    = 3'd3;
	localparam logic [2:0] ST_RANGE   = 3'd4;
	localparam logic [2:0] ST_STALE   = 3'd5;
	localparam logic [2:0] ST_FULL    = 3'd6;

	localparam logic [7:0] HANDLE_FORMAT = 8'd1;
	localparam logic [7:0] CRC_POLY      = 8'h07;
	localparam logic [7:0] CRC_TOP       = 8'h80;
	localparam int         CRC_BYTES     = 120 / 8;
	localparam int         CRC_BITS      = CRC_BYTES * 8;

	localparam int QUEUE_DEPTH = 2;

	typedef logic [CRC_BITS-1:0][7:0] crc_cols_t;

	// one classified request travelling from front to back
	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  status;
		logic [23:0] fid;
		logic [23:0] revision;
		logic [19:0] base;
		logic [63:0] context_word;
	} cha_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [23:0] fid;
		logic [23:0] revision;
		logic [7:0]  version;
		logic [19:0] root;
		logic [19:0] base;
		logic [7:0]  check;
		logic [63:0] context_word;
	} cha_result_t;

	// bit-serial reference form, only evaluated at elaboration
	function automatic logic [7:0] crc_serial(input logic [CRC_BITS-1:0] img);
		logic [7:0] c;
		c = '0;
		for (int i = 0; i < CRC_BYTES; i++) begin
			c = c ^ img[8*i +: 8];
			for (int b = 0; b < 8; b++) begin
				if ((c & CRC_TOP) != 8'd0) begin
					c = (c << 1) ^ CRC_POLY;
				end else begin
					c = c << 1;
				end
			end
		end
		return c;
	endfunction

	function automatic crc_cols_t crc_build_cols();
		crc_cols_t cols;
		logic [CRC_BITS-1:0] unit_v;
		for (int i = 0; i < CRC_BITS; i++) begin
			unit_v = '0;
			unit_v[i] = 1'b1;
			cols[i] = crc_serial(unit_v);
		end
		return cols;
	endfunction

	// CRC of each single set bit; zero init makes the CRC linear
	localparam crc_cols_t CRC_COLS = crc_build_cols();

	function automatic logic [7:0] crc_fast(input logic [CRC_BITS-1:0] img);
		logic [7:0] c;
		c = '0;
		for (int i = 0; i < CRC_BITS; i++) begin
			if (img[i]) begin
				c = c ^ CRC_COLS[i];
			end
		end
		return c;
	endfunction

	// image: word0 = {base, root, revision}, then low 56 bits of word1
	function automatic logic [CRC_BITS-1:0] handle_image(
		input logic [23:0] revision,
		input logic [19:0] root,
		input logic [19:0] base,
		input logic [7:0]  version,
		input logic [23:0] fid,
		input logic [23:0] spare
	);
		return {spare, fid, version, base, root, revision};
	endfunction

endpackage

FILE: design/cha_front.sv
// Front end: takes request beats, checks CRC, version, root and range.
// Root is checked for lookups only. Depends on cha_pkg; feeds cha_queue.
module cha_front #(
	parameter int ENTRIES = cha_pkg::ENTRIES_DEF
) (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [23:0]        handle_fid,
	input  logic [23:0]        handle_revision,
	input  logic [7:0]         handle_version,
	input  logic [19:0]        handle_root,
	input  logic [19:0]        base_value,
	input  logic [23:0]        handle_spare,
	input  logic [7:0]         handle_check,
	input  logic [63:0]        context_in,
	input  logic [19:0]        node_rank,
	input  logic               q_full,
	output logic               push,
	output cha_pkg::cha_item_t item
);

	localparam logic [24:0] ENTRIES_C = 25'(ENTRIES);

	logic [7:0] crc_calc;
	logic [2:0] pre_status;

	assign crc_calc = cha_pkg::crc_fast(cha_pkg::handle_image(handle_revision, handle_root,
		base_value, handle_version, handle_fid, handle_spare));

	always_comb begin
		priority if (crc_calc != handle_check) begin
			pre_status = cha_pkg::ST_CRC;
		end else if (handle_version != cha_pkg::HANDLE_FORMAT) begin
			pre_status = cha_pkg::ST_VERSION;
		end else if (action == cha_pkg::ACT_LOOKUP && handle_root != node_rank) begin
			pre_status = cha_pkg::ST_ROOT;
		end else if ({1'b0, handle_fid} >= ENTRIES_C) begin
			pre_status = cha_pkg::ST_RANGE;
		end else begin
			pre_status = cha_pkg::ST_OK;
		end
	end

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		item.action       = action;
		item.status       = pre_status;
		item.fid          = handle_fid;
		item.revision     = handle_revision;
		item.base         = base_value;
		item.context_word = context_in;
	end

endmodule

FILE: design/cha_queue.sv
// Short FIFO of classified requests between front and back ends.
// Depends on cha_pkg for the item type and depth.
module cha_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cha_pkg::cha_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output cha_pkg::cha_item_t head
);

	localparam int QD  = cha_pkg::QUEUE_DEPTH;
	localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
	localparam int QCW = $clog2(QD + 1);

	cha_pkg::cha_item_t slots_q [QD];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] count_q;

	assign full       = (count_q == QCW'(QD));
	assign head_valid = (count_q != '0);
	assign head       = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QD - 1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QD - 1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (!push && pop) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

endmodule

FILE: design/cha_back.sv
// Back end: entry table, free stack, two-step read/write-back sequencer and
// the result register. Depends on cha_pkg; fed by cha_queue.
module cha_back #(
	parameter int ENTRIES = cha_pkg::ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [19:0]          node_rank,
	input  logic                 head_valid,
	input  cha_pkg::cha_item_t   head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cha_pkg::cha_result_t result
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] ENTRIES_C = CW'(ENTRIES);
	localparam int SW = IW + 24;   // free stack word: {index, generation}
	localparam int TW = 1 + 24 + 64; // table word: {busy, generation, context}

	typedef enum logic [1:0] {
		B_READ = 2'b01,
		B_EXEC = 2'b10
	} cha_bstate_t;

	cha_bstate_t state_q;

	logic [SW-1:0] stk_mem [ENTRIES];
	logic [TW-1:0] tbl_mem [ENTRIES];
	logic [SW-1:0] stk_rd_q;
	logic [TW-1:0] tbl_rd_q;
	logic          stk_fresh_q, tbl_fresh_q;

	// free_cnt_q: stack depth. used_q: slots ever handed out from the
	// untouched tail; below ENTRIES-used_q the stack still holds reset order.
	logic [CW-1:0] free_cnt_q, used_q;

	cha_pkg::cha_result_t out_q;
	logic                 out_valid_q;

	logic          rd_go, exec_go;
	logic [CW-1:0] top_pos;
	logic [IW-1:0] head_idx;

	logic          tbl_we, stk_we, alloc_ok, release_ok;
	logic [IW-1:0] tbl_wa, slot;
	logic [TW-1:0] tbl_wd;
	logic [23:0]   gen_new, tbl_gen;
	logic          tbl_busy;
	cha_pkg::cha_result_t res;

	assign rd_go    = (state_q == B_READ) && head_valid;
	assign exec_go  = (state_q == B_EXEC) && (!out_valid_q || out_ready);
	assign pop      = exec_go;
	assign top_pos  = free_cnt_q - CW'(1);
	assign head_idx = head.fid[IW-1:0];

	assign tbl_busy = !tbl_fresh_q && tbl_rd_q[TW-1];
	assign tbl_gen  = tbl_fresh_q ? 24'd0 : tbl_rd_q[87:64];
	assign slot     = stk_fresh_q ? used_q[IW-1:0] : stk_rd_q[SW-1:24];
	assign gen_new  = (stk_fresh_q ? 24'd0 : stk_rd_q[23:0]) + 24'd1;

	always_comb begin
		res        = '0;
		tbl_we     = 1'b0;
		stk_we     = 1'b0;
		alloc_ok   = 1'b0;
		release_ok = 1'b0;
		tbl_wa     = head_idx;
		tbl_wd     = {1'b0, tbl_gen, tbl_rd_q[63:0]};
		unique case (head.action)
			cha_pkg::ACT_ALLOC: begin
				if (free_cnt_q == '0) begin
					res.status = cha_pkg::ST_FULL;
				end else begin
					alloc_ok         = 1'b1;
					tbl_we           = 1'b1;
					tbl_wa           = slot;
					tbl_wd           = {1'b1, gen_new, head.context_word};
					res.status       = cha_pkg::ST_OK;
					res.fid          = 24'(slot);
					res.revision     = gen_new;
					res.version      = cha_pkg::HANDLE_FORMAT;
					res.root         = node_rank;
					res.base         = head.base;
					res.check        = cha_pkg::crc_fast(cha_pkg::handle_image(gen_new,
						node_rank, head.base, cha_pkg::HANDLE_FORMAT, 24'(slot), 24'd0));
				end
			end
			cha_pkg::ACT_RELEASE, cha_pkg::ACT_LOOKUP: begin
				priority if (head.status != cha_pkg::ST_OK) begin
					res.status = head.status;
				end else if (!tbl_busy || tbl_gen != head.revision) begin
					res.status = cha_pkg::ST_STALE;
				end else if (head.action == cha_pkg::ACT_RELEASE) begin
					release_ok = 1'b1;
					tbl_we     = 1'b1;
					stk_we     = (free_cnt_q != ENTRIES_C);
				end else begin
					res.context_word = tbl_rd_q[63:0];
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// memories: registered read in the read step, write-back in the exec step
	always_ff @(posedge clk) begin
		if (rd_go) begin
			stk_rd_q <= stk_mem[top_pos[IW-1:0]];
		end
		if (exec_go && stk_we) begin
			stk_mem[free_cnt_q[IW-1:0]] <= {head_idx, tbl_gen};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_go) begin
			tbl_rd_q <= tbl_mem[head_idx];
		end
		if (exec_go && tbl_we) begin
			tbl_mem[tbl_wa] <= tbl_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_go) begin
			stk_fresh_q <= (free_cnt_q == ENTRIES_C - used_q);
			tbl_fresh_q <= (CW'(head_idx) >= used_q);
		end
		if (exec_go) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_READ;
			free_cnt_q  <= ENTRIES_C;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_READ: begin
					if (rd_go) begin
						state_q <= B_EXEC;
					end
				end
				B_EXEC: begin
					if (exec_go) begin
						state_q <= B_READ;
					end
				end
				default: begin
					state_q <= B_READ;
				end
			endcase
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (exec_go && alloc_ok) begin
				free_cnt_q <= free_cnt_q - CW'(1);
				if (stk_fresh_q) begin
					used_q <= used_q + CW'(1);
				end
			end else if (exec_go && release_ok && free_cnt_q != ENTRIES_C) begin
				free_cnt_q <= free_cnt_q + CW'(1);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign result    = out_q;

endmodule

FILE: design/checked_handle_allocator_unit.sv
// Top level of the checked handle allocator: node rank register, front end,
// request queue and back end. Depends on cha_pkg, cha_front, cha_queue, cha_back.
//
// Allocates, releases and looks up CRC-8 protected generational handles over a
// table of ENTRIES slots. One result beat per request beat, in order. The back
// end handles each request in a read step (entry table and free stack top) and
// an exec step (write-back and result register load), which waits while an
// unread result is held; a new request is read only after the last one's exec
// step. A 2-deep queue lets requests be accepted while the result register
// waits. No clearing pass after reset: slot and stack contents not yet touched
// are tracked by a fill count. Write node_rank only while the block is idle.
module checked_handle_allocator_unit #(
	parameter int ENTRIES = cha_pkg::ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [19:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [23:0] handle_fid,
	input  logic [23:0] handle_revision,
	input  logic [7:0]  handle_version,
	input  logic [19:0] handle_root,
	input  logic [19:0] base_value,
	input  logic [23:0] handle_spare,
	input  logic [7:0]  handle_check,
	input  logic [63:0] context_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [23:0] out_fid,
	output logic [23:0] out_revision,
	output logic [7:0]  out_version,
	output logic [19:0] out_root,
	output logic [19:0] out_base,
	output logic [7:0]  out_check,
	output logic [63:0] context_out
);

	logic [19:0]          node_rank_q;
	logic                 q_full, push, pop, head_valid;
	cha_pkg::cha_item_t   push_item, head;
	cha_pkg::cha_result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_rank_q <= '0;
		end else if (cfg_wr_en) begin
			node_rank_q <= cfg_wr_data;
		end
	end

	cha_front #(
		.ENTRIES(ENTRIES)
	) u_front (
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.handle_fid      (handle_fid),
		.handle_revision (handle_revision),
		.handle_version  (handle_version),
		.handle_root     (handle_root),
		.base_value      (base_value),
		.handle_spare    (handle_spare),
		.handle_check    (handle_check),
		.context_in      (context_in),
		.node_rank       (node_rank_q),
		.q_full          (q_full),
		.push            (push),
		.item            (push_item)
	);

	cha_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	cha_back #(
		.ENTRIES(ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.node_rank  (node_rank_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result     (result)
	);

	assign status       = result.status;
	assign out_fid      = result.fid;
	assign out_revision = result.revision;
	assign out_version  = result.version;
	assign out_root     = result.root;
	assign out_base     = result.base;
	assign out_check    = result.check;
	assign context_out  = result.context_word;

endmodule
